// ===== design/stream_duplicate_remover_top_defines.svh =====
// ---------------------------------------------------------------------------
// stream_duplicate_remover_top_defines.svh
// Assertion macros used by the duplicate remover checker.
// ---------------------------------------------------------------------------
`ifndef STREAM_DUPLICATE_REMOVER_TOP_DEFINES_SVH
`define STREAM_DUPLICATE_REMOVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define SDR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define SDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sdr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdr_pkg
// Shared widths, defaults and the token flag group of the duplicate remover.
// ---------------------------------------------------------------------------
package sdr_pkg;

  // Field widths of the stream payload
  localparam int DATA_W          = 32;
  localparam int POS_OUT_W       = 6;
  localparam int CNT_OUT_W       = 7;
  localparam int OUT_TDATA_W     = 48;
  localparam int TABLE_DEPTH_DEF = 64;

  // Flags riding with an element as it walks down the chain
  typedef struct packed {
    logic valid;
    logic last;
    logic found;
    logic kept;
  } sdr_flags_t;

endpackage

// ===== design/stream_duplicate_remover_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stream_duplicate_remover_top
// Order-preserving duplicate removal over a stream of array elements.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one array element per transfer, in_tlast on the
//   last element of an array. Result channel out_*: exactly one result per
//   element, in order, out_tlast copying in_tlast.
//   Each element walks a chain of TABLE_DEPTH slot cells, one cell per
//   cycle while the chain advances; every cell compares it against its
//   stored value and the first empty cell takes a new value. The result
//   shows on out_* from the register of the last cell. The chain is
//   pipelined, so one element per cycle is taken while the output flows.
//   The last element of an array empties each cell as it passes, so the
//   next array starts with an empty table with no gap cycle.
//   Reset empties all cells and drops any element in flight.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and in_tready drops in the same cycle; it rises again as soon as the
//   waiting result is taken.
// ---------------------------------------------------------------------------
module stream_duplicate_remover_top
  import sdr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [DATA_W-1:0]      in_tdata,   // [31:0] element
  input  logic                   in_tlast,   // final_element
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] echoed_element, [32] kept, [38:33] kept_position,
  // [45:39] distinct_count, [46] table_overflow, [47] zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast   // array_done
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH+1);

  sdr_flags_t        flg_c [TABLE_DEPTH+1];
  logic [DATA_W-1:0] val_c [TABLE_DEPTH+1];
  logic [IDX_W-1:0]  pos_c [TABLE_DEPTH+1];
  logic [CNT_W-1:0]  cnt_c [TABLE_DEPTH+1];

  logic              adv;
  sdr_flags_t        tail;
  logic [31:0]       pos_ext;
  logic [31:0]       cnt_ext;
  logic              overflow;

  // Chain moves when the output slot is empty or being drained
  assign adv       = ~flg_c[TABLE_DEPTH].valid | out_tready;
  assign in_tready = adv;

  // Chain head: a fresh token from the input port
  always_comb begin
    flg_c[0].valid = in_tvalid;
    flg_c[0].last  = in_tlast;
    flg_c[0].found = 1'b0;
    flg_c[0].kept  = 1'b0;
    val_c[0]       = in_tdata;
    pos_c[0]       = '0;
    cnt_c[0]       = '0;
  end

  // Row of slot cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    sdr_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX         (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .tok_flags (flg_c[g]),
      .tok_val   (val_c[g]),
      .tok_pos   (pos_c[g]),
      .tok_cnt   (cnt_c[g]),
      .nxt_flags (flg_c[g+1]),
      .nxt_val   (val_c[g+1]),
      .nxt_pos   (pos_c[g+1]),
      .nxt_cnt   (cnt_c[g+1])
    );
  end

  // Result formatting from the last cell's register
  assign tail     = flg_c[TABLE_DEPTH];
  assign pos_ext  = 32'(pos_c[TABLE_DEPTH]);
  assign cnt_ext  = 32'(cnt_c[TABLE_DEPTH]);
  assign overflow = ~tail.found & ~tail.kept;

  assign out_tvalid = tail.valid;
  assign out_tlast  = tail.last;
  assign out_tdata  = {1'b0, overflow, cnt_ext[CNT_OUT_W-1:0], pos_ext[POS_OUT_W-1:0],
                       tail.kept, val_c[TABLE_DEPTH]};

endmodule

// ===== design/sdr_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdr_cell
// One table slot: holds a stored value, compares the passing element,
// claims the slot for a new value and hands the token to the next cell.
// ---------------------------------------------------------------------------
module sdr_cell
  import sdr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int IDX         = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  sdr_flags_t                       tok_flags,
  input  logic [DATA_W-1:0]                tok_val,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   tok_pos,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] tok_cnt,
  output sdr_flags_t                       nxt_flags,
  output logic [DATA_W-1:0]                nxt_val,
  output logic [$clog2(TABLE_DEPTH)-1:0]   nxt_pos,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] nxt_cnt
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH+1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX + 1);

  logic [DATA_W-1:0] slot_r;
  logic              occ_r;
  logic              hit;
  logic              take;

  sdr_flags_t        flags_r;
  logic [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]  pos_r;
  logic [CNT_W-1:0]  cnt_r;

  // Match or claim
  assign hit  = tok_flags.valid & occ_r & (slot_r == tok_val);
  assign take = tok_flags.valid & ~occ_r & ~tok_flags.found & ~tok_flags.kept;

  // Slot contents; the last element of an array empties the slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (adv) begin
      if (tok_flags.valid && tok_flags.last) begin
        occ_r <= 1'b0;
      end else if (take) begin
        occ_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      slot_r <= tok_val;
    end
  end

  // Token register toward the neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (adv) begin
      flags_r.valid <= tok_flags.valid;
      flags_r.last  <= tok_flags.last;
      flags_r.found <= tok_flags.found | hit;
      flags_r.kept  <= tok_flags.kept | take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= tok_val;
      pos_r <= take ? MY_IDX : tok_pos;
      cnt_r <= (occ_r || take) ? MY_CNT : tok_cnt;
    end
  end

  assign nxt_flags = flags_r;
  assign nxt_val   = val_r;
  assign nxt_pos   = pos_r;
  assign nxt_cnt   = cnt_r;

endmodule

// ===== design/sdr_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdr_checker
// Port-level checks on the duplicate remover's result stream.
// ---------------------------------------------------------------------------
`include "stream_duplicate_remover_top_defines.svh"

module sdr_checker
  import sdr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(TABLE_DEPTH);

  logic                 r_kept;
  logic [POS_OUT_W-1:0] r_pos;
  logic [CNT_OUT_W-1:0] r_cnt;
  logic [CNT_OUT_W-1:0] r_cnt_m1;
  logic                 r_ovf;

  assign r_kept   = out_tdata[32];
  assign r_pos    = out_tdata[38:33];
  assign r_cnt    = out_tdata[45:39];
  assign r_ovf    = out_tdata[46];
  assign r_cnt_m1 = r_cnt - 7'd1;

  // A kept value lands at the slot just below the new count
  `SDR_ASSERT_IMPL(a_kept_pos, out_tvalid && r_kept,
    r_cnt_m1[POS_OUT_W-1:0] == r_pos, "kept position does not match count")

  // Overflow only with a full table, never together with kept
  `SDR_ASSERT_IMPL(a_ovf_full, out_tvalid && r_ovf,
    !r_kept && r_pos == '0 && r_cnt == FULL_CNT, "overflow without full table")

  // A dropped duplicate reports position zero
  `SDR_ASSERT_IMPL(a_drop_pos, out_tvalid && !r_kept,
    r_pos == '0, "dropped element reports a position")

  // A stalled result holds
  `SDR_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

endmodule

bind stream_duplicate_remover_top sdr_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sdr_checker (.*);

// ===== tb/tb_stream_duplicate_remover_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stream_duplicate_remover_top
// Self-checking bench for the streaming duplicate remover.
// A queue of array elements feeds a clocked stream driver; a clocked monitor
// predicts one result per accepted element from its own copy of the
// distinct-value table and checks every result transfer in order. Both
// sides idle in random bursts, and the receiver once holds off long enough
// to back the chain up into the input. Arrays include single elements,
// heavy repeats, field extremes and tables that fill up and overflow.
// ---------------------------------------------------------------------------
module tb_stream_duplicate_remover_top;
  import sdr_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_TAIL  = 80;
  localparam int RAND_ITEMS  = 550;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              last;
  } element_t;

  typedef struct packed {
    logic [DATA_W-1:0]    value;
    logic                 kept;
    logic [POS_OUT_W-1:0] pos;
    logic [CNT_OUT_W-1:0] count;
    logic                 overflow;
    logic                 pad;
    logic                 done;
  } dedup_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Stimulus and scoreboard
  element_t      element_q[$];
  dedup_result_t dedup_expected_q[$];
  int            total_items;
  int            accepted_cnt;
  int            errors;
  int            cycle_cnt;
  logic          in_fire;

  // Predictor state: distinct values of the current array
  logic [DATA_W-1:0] seen_vals [DEPTH];
  int unsigned       seen_cnt;

  // Idle and hold-off counters
  int in_idle;
  int out_idle;
  int hold_left;
  bit hold_done;

  stream_duplicate_remover_top #(
    .TABLE_DEPTH (DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Expected result of one element; updates the distinct-value table
  function automatic dedup_result_t dedup_predict(input logic [DATA_W-1:0] v,
                                                  input logic last);
    dedup_result_t r;
    bit            hit;
    hit = 1'b0;
    for (int i = 0; i < int'(seen_cnt); i++) begin
      if (seen_vals[i] == v) hit = 1'b1;
    end
    r.value    = v;
    r.kept     = 1'b0;
    r.pos      = '0;
    r.overflow = 1'b0;
    r.pad      = 1'b0;
    r.done     = last;
    if (!hit) begin
      if (seen_cnt < DEPTH) begin
        seen_vals[seen_cnt] = v;
        r.pos  = POS_OUT_W'(seen_cnt);
        r.kept = 1'b1;
        seen_cnt++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    r.count = CNT_OUT_W'(seen_cnt);
    if (last) seen_cnt = 0;
    return r;
  endfunction

  task automatic push_element(input logic [DATA_W-1:0] d, input logic l);
    element_q.push_back('{data: d, last: l});
  endtask

  // No idling in the tail, and none in every fourth stretch of 50 items
  function automatic bit quiet_now();
    return (element_q.size() <= QUIET_TAIL) || ((element_q.size() / 50) % 4 == 1);
  endfunction

  // Input driver: new item only after the current one was transferred
  always @(negedge clk) begin
    element_t it;
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (in_idle > 0) begin
          in_idle--;
          in_tvalid <= 1'b0;
        end else if (element_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!quiet_now() && $urandom_range(0, 5) == 0) begin
          in_idle = $urandom_range(0, 17);
          in_tvalid <= 1'b0;
        end else begin
          it = element_q.pop_front();
          in_tdata  <= it.data;
          in_tlast  <= it.last;
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // Long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_cnt >= 200) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end
    end
  end

  // Result receiver: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (out_idle > 0) begin
        out_idle--;
        out_tready <= 1'b0;
      end else if (!quiet_now() && $urandom_range(0, 5) == 0) begin
        out_idle = $urandom_range(0, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input transfers, check on result transfers
  always @(posedge clk) begin
    dedup_result_t got;
    dedup_result_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        dedup_expected_q.push_back(dedup_predict(in_tdata, in_tlast));
        accepted_cnt++;
      end
      if (out_tvalid && out_tready) begin
        got.value    = out_tdata[31:0];
        got.kept     = out_tdata[32];
        got.pos      = out_tdata[38:33];
        got.count    = out_tdata[45:39];
        got.overflow = out_tdata[46];
        got.pad      = out_tdata[47];
        got.done     = out_tlast;
        if (dedup_expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: value=%h kept=%b pos=%0d cnt=%0d ovf=%b last=%b",
                     got.value, got.kept, got.pos, got.count, got.overflow, got.done);
        end else begin
          want = dedup_expected_q.pop_front();
          if (got.value !== want.value || got.kept !== want.kept ||
              got.pos !== want.pos || got.count !== want.count ||
              got.overflow !== want.overflow || got.pad !== want.pad ||
              got.done !== want.done) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp: value=%h kept=%b pos=%0d cnt=%0d ovf=%b pad=%b last=%b",
                       want.value, want.kept, want.pos, want.count, want.overflow,
                       want.pad, want.done);
              $display("         got: value=%h kept=%b pos=%0d cnt=%0d ovf=%b pad=%b last=%b",
                       got.value, got.kept, got.pos, got.count, got.overflow,
                       got.pad, got.done);
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [DATA_W-1:0] pool [6];
    logic [DATA_W-1:0] extremes [6];
    logic [DATA_W-1:0] base;
    int                rand_items;
    int                len;
    int                mode;
    int                wide_done;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    in_fire      = 1'b0;
    seen_cnt     = 0;
    accepted_cnt = 0;
    errors       = 0;
    cycle_cnt    = 0;
    in_idle      = 0;
    out_idle     = 0;
    hold_left    = 0;
    hold_done    = 1'b0;

    extremes = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE};

    // Directed: one-element array, extremes with repeats, constant run,
    // fresh table after the last element
    push_element(32'h8000_0000, 1'b1);
    push_element(32'h7FFF_FFFF, 1'b0);
    push_element(32'h8000_0000, 1'b0);
    push_element(32'h0000_0000, 1'b0);
    push_element(32'hFFFF_FFFF, 1'b0);
    push_element(32'h7FFF_FFFF, 1'b0);
    push_element(32'h0000_0000, 1'b0);
    push_element(32'h0000_0001, 1'b0);
    push_element(32'hFFFF_FFFF, 1'b1);
    push_element(32'h0000_0005, 1'b0);
    push_element(32'h0000_0005, 1'b0);
    push_element(32'h0000_0005, 1'b0);
    push_element(32'h0000_0005, 1'b1);
    push_element(32'h7FFF_FFFF, 1'b0);
    push_element(32'h0000_0005, 1'b0);
    push_element(32'h0000_0001, 1'b1);
    push_element(32'h8000_0000, 1'b0);
    push_element(32'h8000_0000, 1'b1);
    push_element(32'hFFFF_FFFF, 1'b1);
    push_element(32'hFFFF_FFFF, 1'b1);

    // Random arrays; three wide ones fill the table, and the later two can also overflow it
    rand_items = 0;
    wide_done  = 0;
    while (rand_items < RAND_ITEMS) begin
      if (wide_done < 3 && rand_items >= wide_done * 150 + 60) begin
        len  = (wide_done == 0) ? DEPTH : DEPTH + $urandom_range(2, 16);
        base = $urandom;
        for (int i = 0; i < len; i++) begin
          if (i < DEPTH)
            push_element(base + i, i == len - 1);
          else if ($urandom_range(0, 1) == 0)
            push_element(base + $urandom_range(0, DEPTH - 1), i == len - 1);
          else
            push_element(base + i, i == len - 1);
        end
        wide_done++;
      end else begin
        mode = $urandom_range(0, 19);
        if (mode <= 8) begin
          len = $urandom_range(1, 24);
          for (int k = 0; k < 6; k++)
            pool[k] = ($urandom_range(0, 3) == 0) ? extremes[$urandom_range(0, 5)] : $urandom;
          for (int i = 0; i < len; i++)
            push_element(pool[$urandom_range(0, 5)], i == len - 1);
        end else if (mode <= 13) begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++)
            push_element($urandom, i == len - 1);
        end else if (mode <= 16) begin
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++)
            push_element(extremes[$urandom_range(0, 5)], i == len - 1);
        end else begin
          len = $urandom_range(1, 30);
          for (int i = 0; i < len; i++)
            push_element($urandom_range(0, 15), i == len - 1);
        end
      end
      rand_items += len;
    end
    total_items = element_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all elements in, all results out, then an idle wait before the verdict
    while (accepted_cnt < total_items || dedup_expected_q.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);

    if (errors == 0 && dedup_expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
